/* hdl/mse_pkg.sv */
// Shared types and constants for the MIPS subset execute unit.
// Holds the operation codes, the channel payload structs and the decoded queue entry.
// No dependencies.
`timescale 1ns / 1ps

package mse_pkg;

   // Default sizes; the memory depth must be a power of two.
   localparam int MEM_WORDS_DEF = 65536;
   localparam int PC_BITS_DEF   = 16;

   localparam int NUM_REGS = 32;
   localparam int REG_AW   = 5;
   localparam int OP_W     = 5;

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;
   localparam int Q_CW    = 2;

   localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_AW-1:0] REG_LINK = 5'd31;

   localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
   localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
   localparam logic [OP_W-1:0] OP_AND  = 5'd2;
   localparam logic [OP_W-1:0] OP_OR   = 5'd3;
   localparam logic [OP_W-1:0] OP_XOR  = 5'd4;
   localparam logic [OP_W-1:0] OP_NOR  = 5'd5;
   localparam logic [OP_W-1:0] OP_SLT  = 5'd6;
   localparam logic [OP_W-1:0] OP_SRL  = 5'd7;
   localparam logic [OP_W-1:0] OP_SLL  = 5'd8;
   localparam logic [OP_W-1:0] OP_JR   = 5'd9;
   localparam logic [OP_W-1:0] OP_JALR = 5'd10;
   localparam logic [OP_W-1:0] OP_ADDI = 5'd11;
   localparam logic [OP_W-1:0] OP_ANDI = 5'd12;
   localparam logic [OP_W-1:0] OP_ORI  = 5'd13;
   localparam logic [OP_W-1:0] OP_XORI = 5'd14;
   localparam logic [OP_W-1:0] OP_LUI  = 5'd15;
   localparam logic [OP_W-1:0] OP_LW   = 5'd16;
   localparam logic [OP_W-1:0] OP_SW   = 5'd17;
   localparam logic [OP_W-1:0] OP_BEQ  = 5'd18;
   localparam logic [OP_W-1:0] OP_BNE  = 5'd19;
   localparam logic [OP_W-1:0] OP_SLTI = 5'd20;
   localparam logic [OP_W-1:0] OP_J    = 5'd21;
   localparam logic [OP_W-1:0] OP_JAL  = 5'd22;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [REG_AW-1:0] dest_reg;
      logic [REG_AW-1:0] src_reg_a;
      logic [REG_AW-1:0] src_reg_b;
      logic signed [31:0] immediate;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic               reg_written;
      logic [REG_AW-1:0]  written_reg;
      logic signed [31:0] written_value;
      logic               mem_written;
      logic [15:0]        mem_word_index;
      logic               branch_taken;
   } rsp_payload_type;

   // One classified instruction as it waits between the front and the back.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic              wr_en;      // writes a register other than zero
      logic [REG_AW-1:0] wreg;       // zero when nothing is written
      logic [REG_AW-1:0] addr_a;
      logic [REG_AW-1:0] addr_b;
      logic              jalr_self;  // jalr whose link register is its source
      logic              use_imm;
      logic [31:0]       alu_imm;
      logic [31:0]       tgt;
   } dec_type;

endpackage

/* hdl/mse_front.sv */
// Front end of the execute unit: takes request beats and classifies them.
// Produces a decoded queue entry; depends on mse_pkg.
`timescale 1ns / 1ps

module mse_front
   import mse_pkg::*;
(
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            q_ready,
   input  logic            clr_busy,
   output logic            q_push,
   output dec_type         q_wdata
);

   logic [OP_W-1:0]   op;
   logic [REG_AW-1:0] r1;
   logic [REG_AW-1:0] r2;
   logic [REG_AW-1:0] r3;
   logic [31:0]       imm;
   logic              wr_raw;
   logic [REG_AW-1:0] wreg_raw;

   assign req_ready = q_ready && !clr_busy;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      op  = req_payload.req_type;
      r1  = req_payload.dest_reg;
      r2  = req_payload.src_reg_a;
      r3  = req_payload.src_reg_b;
      imm = req_payload.immediate;

      wr_raw = (op inside {[OP_ADD:OP_SLL], [OP_JALR:OP_LW], OP_SLTI, OP_JAL});
      if (op == OP_JALR) begin
         wreg_raw = r2;
      end else if (op == OP_JAL) begin
         wreg_raw = REG_LINK;
      end else begin
         wreg_raw = r1;
      end

      q_wdata.op        = op;
      q_wdata.wr_en     = wr_raw && (wreg_raw != REG_ZERO);
      q_wdata.wreg      = q_wdata.wr_en ? wreg_raw : REG_ZERO;
      q_wdata.addr_a    = (op inside {OP_JR, OP_JALR, OP_BEQ, OP_BNE, OP_SW}) ? r1 : r2;
      q_wdata.addr_b    = (op inside {OP_BEQ, OP_BNE}) ? r2 : r3;
      q_wdata.jalr_self = (r1 == r2) && (r2 != REG_ZERO);
      q_wdata.use_imm   = (op inside {[OP_ADDI:OP_LUI], OP_SLTI});
      q_wdata.tgt       = (op inside {OP_BEQ, OP_BNE}) ? (imm - 32'd1) : imm;

      case (op)
         OP_ANDI, OP_ORI, OP_XORI: q_wdata.alu_imm = {16'h0000, imm[15:0]};
         OP_SLTI:                  q_wdata.alu_imm = {{16{imm[15]}}, imm[15:0]};
         OP_LUI:                   q_wdata.alu_imm = {imm[15:0], 16'h0000};
         OP_LW, OP_SW:             q_wdata.alu_imm = {{2{imm[31]}}, imm[31:2]};
         default:                  q_wdata.alu_imm = imm;
      endcase
   end

endmodule

/* hdl/mse_queue.sv */
// Two-entry queue that decouples the front end from the execute back end.
// Carries decoded instructions; depends on mse_pkg.
`timescale 1ns / 1ps

module mse_queue
   import mse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  dec_type wdata,
   output logic    ready,
   input  logic    pop,
   output logic    valid,
   output dec_type rdata
);

   dec_type         entry_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff;
   logic [Q_AW-1:0] wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff;
   logic [Q_AW-1:0] rd_ptr_in;
   logic [Q_CW-1:0] count_ff;
   logic [Q_CW-1:0] count_in;

   assign ready = (count_ff != Q_CW'(Q_DEPTH));
   assign valid = (count_ff != '0);
   assign rdata = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + Q_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* hdl/mse_back.sv */
// Back end of the execute unit: register file, data memory, program counter and
// a two-stage execute pipe whose second stage is the response register. Depends on mse_pkg.
`timescale 1ns / 1ps

module mse_back
   import mse_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int PC_BITS   = PC_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  dec_type         q_data,
   output logic            q_pop,
   output logic            clr_busy,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int MEM_AW = $clog2(MEM_WORDS);

   // Register file with per-entry valid bits so reset reads as zero.
   logic [31:0]         rf_ff [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;
   logic [31:0]         rd_a_ff;
   logic [31:0]         rd_b_ff;
   logic                rf_we;
   logic [REG_AW-1:0]   rf_waddr;
   logic [31:0]         rf_wdata;

   // Data memory and its clearing pass.
   logic [31:0]       dmem_ff [MEM_WORDS];
   logic [31:0]       dmem_rdata_ff;
   logic              dmem_we;
   logic              dmem_re;
   logic [MEM_AW-1:0] dmem_addr;
   logic [31:0]       dmem_wdata;
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [MEM_AW-1:0] clr_cnt_ff;
   logic [MEM_AW-1:0] clr_cnt_in;

   // First execute stage.
   logic         e1_valid_ff;
   logic         e1_valid_in;
   dec_type      e1_dec_ff;
   logic         e1_adv;
   logic [31:0]  op_a;
   logic [31:0]  op_b;
   logic [31:0]  b_sel;
   logic [31:0]  mem_sum;
   logic [31:0]  link;
   logic [PC_BITS-1:0] pc_inc;
   logic [PC_BITS-1:0] e1_pc;
   logic [31:0]  e1_val;
   logic         e1_taken;
   logic         e1_mw;
   logic         e1_load;
   logic [MEM_AW-1:0] e1_midx;

   logic [PC_BITS-1:0] pc_ff;
   logic [PC_BITS-1:0] pc_in;

   // Second execute stage, which is also the response register.
   logic               e2_valid_ff;
   logic               e2_valid_in;
   logic [PC_BITS-1:0] e2_pc_ff;
   logic               e2_wr_ff;
   logic [REG_AW-1:0]  e2_wreg_ff;
   logic [31:0]        e2_wval_ff;
   logic               e2_load_ff;
   logic               e2_mw_ff;
   logic [MEM_AW-1:0]  e2_midx_ff;
   logic               e2_taken_ff;
   logic [31:0]        e2_wval_out;
   logic               retire;
   logic [31:0]        pc_wide;
   logic [31:0]        midx_wide;

   assign retire  = e2_valid_ff && rsp_ready;
   assign e1_adv  = e1_valid_ff && (!e2_valid_ff || retire);
   assign q_pop   = q_valid && (!e1_valid_ff || e1_adv);
   assign clr_busy = clr_busy_ff;

   assign e2_wval_out = e2_load_ff ? dmem_rdata_ff : e2_wval_ff;
   assign rf_we    = retire && e2_wr_ff;
   assign rf_waddr = e2_wreg_ff;
   assign rf_wdata = e2_wval_out;

   // Register read at pop time; a write retiring on the same edge is passed through.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         if (rf_we && (rf_waddr == q_data.addr_a)) begin
            rd_a_ff <= rf_wdata;
         end else if (rf_vld_ff[q_data.addr_a]) begin
            rd_a_ff <= rf_ff[q_data.addr_a];
         end else begin
            rd_a_ff <= '0;
         end
         if (rf_we && (rf_waddr == q_data.addr_b)) begin
            rd_b_ff <= rf_wdata;
         end else if (rf_vld_ff[q_data.addr_b]) begin
            rd_b_ff <= rf_ff[q_data.addr_b];
         end else begin
            rd_b_ff <= '0;
         end
      end
      if (rf_we) begin
         rf_ff[rf_waddr] <= rf_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_waddr] <= 1'b1;
      end
   end

   // Execute stage one: operands are forwarded from the instruction still in stage two.
   always_comb begin
      op_a = (e2_valid_ff && e2_wr_ff && (e2_wreg_ff == e1_dec_ff.addr_a)) ?
             e2_wval_out : rd_a_ff;
      op_b = (e2_valid_ff && e2_wr_ff && (e2_wreg_ff == e1_dec_ff.addr_b)) ?
             e2_wval_out : rd_b_ff;
      b_sel   = e1_dec_ff.use_imm ? e1_dec_ff.alu_imm : op_b;
      mem_sum = e1_dec_ff.alu_imm + {{2{op_b[31]}}, op_b[31:2]};
      pc_inc  = pc_ff + PC_BITS'(1);
      link    = 32'(pc_inc) + 32'd1;

      e1_pc    = pc_inc;
      e1_val   = '0;
      e1_taken = 1'b0;
      e1_mw    = 1'b0;
      e1_load  = 1'b0;
      e1_midx  = '0;

      case (e1_dec_ff.op)
         OP_ADD, OP_ADDI: e1_val = op_a + b_sel;
         OP_SUB:          e1_val = op_a - op_b;
         OP_AND, OP_ANDI: e1_val = op_a & b_sel;
         OP_OR, OP_ORI:   e1_val = op_a | b_sel;
         OP_XOR, OP_XORI: e1_val = op_a ^ b_sel;
         OP_NOR:          e1_val = ~(op_a | op_b);
         OP_SLT, OP_SLTI: e1_val = ($signed(op_a) < $signed(b_sel)) ? 32'd1 : 32'd0;
         OP_SRL:          e1_val = op_a >> e1_dec_ff.alu_imm[4:0];
         OP_SLL:          e1_val = op_a << e1_dec_ff.alu_imm[4:0];
         OP_LUI:          e1_val = e1_dec_ff.alu_imm;
         OP_JR: begin
            e1_pc    = op_a[PC_BITS-1:0];
            e1_taken = 1'b1;
         end
         OP_JALR: begin
            // The link is written first, so a self-linked jalr jumps to the link.
            e1_val   = link;
            e1_pc    = e1_dec_ff.jalr_self ? link[PC_BITS-1:0] : op_a[PC_BITS-1:0];
            e1_taken = 1'b1;
         end
         OP_LW: begin
            e1_midx = mem_sum[MEM_AW-1:0];
            e1_load = e1_dec_ff.wr_en;
         end
         OP_SW: begin
            e1_midx = mem_sum[MEM_AW-1:0];
            e1_mw   = 1'b1;
         end
         OP_BEQ, OP_BNE: begin
            if ((e1_dec_ff.op == OP_BEQ) == (op_a == op_b)) begin
               e1_pc    = e1_dec_ff.tgt[PC_BITS-1:0];
               e1_taken = 1'b1;
            end
         end
         OP_J: begin
            e1_pc    = e1_dec_ff.tgt[PC_BITS-1:0];
            e1_taken = 1'b1;
         end
         OP_JAL: begin
            e1_val   = link;
            e1_pc    = e1_dec_ff.tgt[PC_BITS-1:0];
            e1_taken = 1'b1;
         end
         default: e1_val = '0;
      endcase

      e1_valid_in = q_pop || (e1_valid_ff && !e1_adv);
      e2_valid_in = e1_adv || (e2_valid_ff && !retire);
      pc_in       = e1_adv ? e1_pc : pc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
         e2_valid_ff <= 1'b0;
         pc_ff       <= '0;
      end else begin
         e1_valid_ff <= e1_valid_in;
         e2_valid_ff <= e2_valid_in;
         pc_ff       <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         e1_dec_ff <= q_data;
      end
      if (e1_adv) begin
         e2_pc_ff    <= e1_pc;
         e2_wr_ff    <= e1_dec_ff.wr_en;
         e2_wreg_ff  <= e1_dec_ff.wreg;
         e2_wval_ff  <= e1_dec_ff.wr_en ? e1_val : '0;
         e2_load_ff  <= e1_load;
         e2_mw_ff    <= e1_mw;
         e2_midx_ff  <= e1_midx;
         e2_taken_ff <= e1_taken;
      end
   end

   // Data memory: a store writes and a load reads as the instruction leaves stage one.
   always_comb begin
      dmem_we    = clr_busy_ff || (e1_adv && (e1_dec_ff.op == OP_SW));
      dmem_re    = e1_adv && (e1_dec_ff.op == OP_LW);
      dmem_addr  = clr_busy_ff ? clr_cnt_ff : e1_midx;
      dmem_wdata = clr_busy_ff ? 32'd0 : op_a;
      clr_busy_in = clr_busy_ff && (clr_cnt_ff != MEM_AW'(MEM_WORDS - 1));
      clr_cnt_in  = clr_busy_ff ? clr_cnt_ff + MEM_AW'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (dmem_we) begin
         dmem_ff[dmem_addr] <= dmem_wdata;
      end
      if (dmem_re) begin
         dmem_rdata_ff <= dmem_ff[dmem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   always_comb begin
      pc_wide   = 32'(e2_pc_ff);
      midx_wide = 32'(e2_midx_ff);
      rsp_valid = e2_valid_ff;
      rsp_payload.next_pc        = pc_wide[15:0];
      rsp_payload.reg_written    = e2_wr_ff;
      rsp_payload.written_reg    = e2_wreg_ff;
      rsp_payload.written_value  = e2_wval_out;
      rsp_payload.mem_written    = e2_mw_ff;
      rsp_payload.mem_word_index = midx_wide[15:0];
      rsp_payload.branch_taken   = e2_taken_ff;
   end

`ifndef SYNTHESIS
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> (!e1_valid_ff && !e2_valid_ff && !q_pop))
      else $error("instruction in flight during memory clear");

   a_store_no_reg: assert property (@(posedge clock) disable iff (reset)
      (e2_valid_ff && e2_mw_ff) |-> (!e2_wr_ff && !e2_taken_ff && !e2_load_ff))
      else $error("store also reports a register write or a jump");

   a_no_reg_zero: assert property (@(posedge clock) disable iff (reset)
      (e2_valid_ff && e2_wr_ff) |-> (e2_wreg_ff != REG_ZERO))
      else $error("write to register zero reported");

   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !e1_adv |=> $stable(pc_ff))
      else $error("program counter moved without an instruction leaving stage one");
`endif

endmodule

/* hdl/mips_subset_execute_unit.sv */
// Channel    Dir  Handshake              Payload
// req_       in   req_valid/req_ready    req_payload_type, one pre-decoded instruction
// rsp_       out  rsp_valid/rsp_ready    rsp_payload_type, what the instruction did
//
// Sustained rate is one instruction per clock while rsp_ready is high; results are registered.
// Loads, stores and dependent instructions run back to back through operand forwarding.
// After reset the data memory is zeroed one word per cycle, all MEM_WORDS words
// (65536 by default), with req_ready held low; the register file and PC clear at once.
// A two-entry queue between the classifier and the execute pipe absorbs output stalls.
// Depends on mse_pkg, mse_front, mse_queue and mse_back.
`timescale 1ns / 1ps

module mips_subset_execute_unit
   import mse_pkg::*;
#(
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int PC_BITS   = PC_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic    q_push;
   logic    q_ready;
   logic    q_pop;
   logic    q_valid;
   logic    clr_busy;
   dec_type q_wdata;
   dec_type q_rdata;

   mse_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_ready     (q_ready),
      .clr_busy    (clr_busy),
      .q_push      (q_push),
      .q_wdata     (q_wdata)
   );

   mse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .ready (q_ready),
      .pop   (q_pop),
      .valid (q_valid),
      .rdata (q_rdata)
   );

   mse_back #(
      .MEM_WORDS (MEM_WORDS),
      .PC_BITS   (PC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_data      (q_rdata),
      .q_pop       (q_pop),
      .clr_busy    (clr_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/sv/tb_mips_subset_execute_unit.sv */
// Self-checking testbench for mips_subset_execute_unit: directed corner cases, then random
// instruction streams, checked against an in-bench model of registers, memory and PC.
// Depends on mse_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit;
   import mse_pkg::*;

   // The limit must cover the memory clear after reset; the rest is a wide margin.
   localparam int CYCLE_LIMIT = 1000000;
   localparam int NUM_INSTRS  = 1800;
   localparam int TAIL_CYCLES = 20;

   // Operation codes above jal are spare and act as no operation.
   localparam logic [OP_W-1:0] OP_SPARE_LO = 5'd23;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 5'd31;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   mips_subset_execute_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Architectural state as the instruction stream should leave it.
   logic [31:0] shadow_regs [NUM_REGS];
   bit   [31:0] shadow_mem [MEM_WORDS_DEF];
   logic [15:0] shadow_pc;

   req_payload_type pending_instrs [$];
   rsp_payload_type expected_results [$];
   int              drain_points [$];

   int  cycle_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  mismatches = 0;
   int  load_count = 0;
   int  store_count = 0;
   int  taken_count = 0;
   int  directed_count;
   int  gap_left = 0;
   int  stall_left = 0;
   logic req_beat = 1'b0;

   function automatic logic [31:0] read_reg(logic [REG_AW-1:0] idx);
      return (idx == REG_ZERO) ? 32'd0 : shadow_regs[idx];
   endfunction

   function automatic logic [15:0] word_slot(logic [31:0] offset, logic [31:0] base);
      logic [31:0] sum;
      sum = ($signed(offset) >>> 2) + ($signed(base) >>> 2);
      return sum[15:0];
   endfunction

   // Applies one instruction to the shadow state and returns what the unit should report.
   function automatic rsp_payload_type execute_instr(req_payload_type ins);
      logic [31:0]       a, b, imm, simm16, wval, other;
      logic [15:0]       pc, midx;
      logic [REG_AW-1:0] wreg;
      logic              wr, mw, taken;
      rsp_payload_type   res;
      pc = shadow_pc + 16'd1;
      a = read_reg(ins.src_reg_a);
      b = read_reg(ins.src_reg_b);
      imm = ins.immediate;
      simm16 = {{16{imm[15]}}, imm[15:0]};
      other = read_reg(ins.dest_reg);
      wr = 1'b0;
      mw = 1'b0;
      taken = 1'b0;
      wreg = ins.dest_reg;
      wval = '0;
      midx = '0;
      case (ins.req_type)
         OP_ADD:  begin wr = 1'b1; wval = a + b; end
         OP_SUB:  begin wr = 1'b1; wval = a - b; end
         OP_AND:  begin wr = 1'b1; wval = a & b; end
         OP_OR:   begin wr = 1'b1; wval = a | b; end
         OP_XOR:  begin wr = 1'b1; wval = a ^ b; end
         OP_NOR:  begin wr = 1'b1; wval = ~(a | b); end
         OP_SLT:  begin wr = 1'b1; wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; end
         OP_SRL:  begin wr = 1'b1; wval = a >> imm[4:0]; end
         OP_SLL:  begin wr = 1'b1; wval = a << imm[4:0]; end
         OP_JR: begin
            pc = other[15:0];
            taken = 1'b1;
         end
         OP_JALR: begin
            // The link lands before the source is read, so a shared register jumps to the link.
            wr = 1'b1;
            wreg = ins.src_reg_a;
            wval = {16'd0, pc} + 32'd1;
            if (ins.src_reg_a != REG_ZERO) begin
               shadow_regs[ins.src_reg_a] = wval;
            end
            other = read_reg(ins.dest_reg);
            pc = other[15:0];
            taken = 1'b1;
         end
         OP_ADDI: begin wr = 1'b1; wval = a + imm; end
         OP_ANDI: begin wr = 1'b1; wval = a & {16'd0, imm[15:0]}; end
         OP_ORI:  begin wr = 1'b1; wval = a | {16'd0, imm[15:0]}; end
         OP_XORI: begin wr = 1'b1; wval = a ^ {16'd0, imm[15:0]}; end
         OP_LUI:  begin wr = 1'b1; wval = {imm[15:0], 16'd0}; end
         OP_LW: begin
            midx = word_slot(imm, b);
            wr = 1'b1;
            wval = shadow_mem[midx];
         end
         OP_SW: begin
            midx = word_slot(imm, b);
            shadow_mem[midx] = other;
            mw = 1'b1;
         end
         OP_BEQ, OP_BNE: begin
            if ((ins.req_type == OP_BEQ) == (other == a)) begin
               pc = imm[15:0] - 16'd1;
               taken = 1'b1;
            end
         end
         OP_SLTI: begin wr = 1'b1; wval = ($signed(a) < $signed(simm16)) ? 32'd1 : 32'd0; end
         OP_J: begin
            pc = imm[15:0];
            taken = 1'b1;
         end
         OP_JAL: begin
            wr = 1'b1;
            wreg = REG_LINK;
            wval = {16'd0, pc} + 32'd1;
            pc = imm[15:0];
            taken = 1'b1;
         end
         default: ;
      endcase
      if (wr && wreg != REG_ZERO) begin
         shadow_regs[wreg] = wval;
      end else begin
         wr = 1'b0;
         wreg = REG_ZERO;
         wval = '0;
      end
      shadow_pc = pc;
      res.next_pc = pc;
      res.reg_written = wr;
      res.written_reg = wreg;
      res.written_value = wval;
      res.mem_written = mw;
      res.mem_word_index = midx;
      res.branch_taken = taken;
      return res;
   endfunction

   function automatic req_payload_type make_instr(logic [OP_W-1:0] op, logic [REG_AW-1:0] d,
                                                  logic [REG_AW-1:0] sa, logic [REG_AW-1:0] sb,
                                                  logic [31:0] imm);
      req_payload_type ins;
      ins.req_type = op;
      ins.dest_reg = d;
      ins.src_reg_a = sa;
      ins.src_reg_b = sb;
      ins.immediate = imm;
      return ins;
   endfunction

   // Low registers are favored so that results feed later instructions often.
   function automatic logic [REG_AW-1:0] pick_reg();
      if ($urandom_range(0, 99) < 70) begin
         return REG_AW'($urandom_range(0, 7));
      end
      return REG_AW'($urandom_range(0, NUM_REGS - 1));
   endfunction

   function automatic req_payload_type random_instr();
      req_payload_type ins;
      int              r;
      if ($urandom_range(0, 99) < 4) begin
         ins.req_type = OP_W'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
      end else begin
         ins.req_type = OP_W'($urandom_range(int'(OP_ADD), int'(OP_JAL)));
      end
      ins.dest_reg = pick_reg();
      ins.src_reg_a = pick_reg();
      ins.src_reg_b = pick_reg();
      r = $urandom_range(0, 99);
      if (r < 35) begin
         ins.immediate = $urandom;
      end else if (r < 65) begin
         ins.immediate = $urandom_range(0, 127) - 64;
      end else begin
         ins.immediate = $urandom_range(0, 63) << 2;
      end
      // Comparing a register with itself makes equal operands common.
      if ((ins.req_type == OP_BEQ || ins.req_type == OP_BNE) && $urandom_range(0, 2) == 0) begin
         ins.src_reg_a = ins.dest_reg;
      end
      return ins;
   endfunction

   // In one of every five equal windows of the cycle count, both sides run without idling.
   function automatic int draw_idle();
      int r;
      if ((cycle_count / 700) % 5 == 0) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Instruction driver.
   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_valid;
      if (!reset && !(req_valid && !req_beat)) begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (drain_points.size() != 0 && sent_count == drain_points[0] &&
                      expected_results.size() != 0) begin
            // Hold off until every outstanding result has come back.
         end else if (pending_instrs.size() != 0) begin
            if (drain_points.size() != 0 && sent_count == drain_points[0]) begin
               void'(drain_points.pop_front());
            end
            req_payload <= pending_instrs.pop_front();
            next_valid = 1'b1;
            sent_count++;
            gap_left = draw_idle();
         end
      end
      req_valid <= next_valid;
   end

   // Result receiver back-pressure.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < 20) begin
            stall_left = draw_idle();
         end
      end
   end

   // Monitor: predicts on each request beat and checks each result beat.
   always @(posedge clock) begin
      rsp_payload_type want;
      req_beat <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(execute_instr(req_payload));
            if (req_payload.req_type == OP_LW) load_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("Result beat arrived with no instruction outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("next_pc", 32'(want.next_pc), 32'(rsp_payload.next_pc));
               check_field("reg_written", 32'(want.reg_written),
                           32'(rsp_payload.reg_written));
               check_field("written_reg", 32'(want.written_reg),
                           32'(rsp_payload.written_reg));
               check_field("written_value", want.written_value, rsp_payload.written_value);
               check_field("mem_written", 32'(want.mem_written),
                           32'(rsp_payload.mem_written));
               check_field("mem_word_index", 32'(want.mem_word_index),
                           32'(rsp_payload.mem_word_index));
               check_field("branch_taken", 32'(want.branch_taken),
                           32'(rsp_payload.branch_taken));
               checked_count++;
               if (want.mem_written) store_count++;
               if (want.branch_taken) taken_count++;
            end
         end
      end
   end

   initial begin
      logic [REG_AW-1:0] base, src, dst;
      logic [31:0]       offset;
      for (int i = 0; i < NUM_REGS; i++) begin
         shadow_regs[i] = '0;
      end
      shadow_pc = '0;

      // Directed corner cases: operand extremes, most operations, register zero,
      // memory index wrap, PC wrap, and a jalr whose link register is its source.
      pending_instrs.push_back(make_instr(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h1234_8000));
      pending_instrs.push_back(make_instr(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF));
      pending_instrs.push_back(make_instr(OP_ADDI, 5'd3, 5'd1, 5'd0, 32'h7FFF_FFFF));
      pending_instrs.push_back(make_instr(OP_ADD, 5'd4, 5'd1, 5'd1, 32'd0));
      pending_instrs.push_back(make_instr(OP_SUB, 5'd5, 5'd0, 5'd2, 32'd0));
      pending_instrs.push_back(make_instr(OP_AND, 5'd6, 5'd2, 5'd1, 32'd0));
      pending_instrs.push_back(make_instr(OP_NOR, 5'd9, 5'd0, 5'd0, 32'd0));
      pending_instrs.push_back(make_instr(OP_SLT, 5'd10, 5'd1, 5'd2, 32'd0));
      pending_instrs.push_back(make_instr(OP_SRL, 5'd11, 5'd1, 5'd0, 32'hFFFF_FFFF));
      pending_instrs.push_back(make_instr(OP_SLL, 5'd12, 5'd2, 5'd0, 32'd32));
      pending_instrs.push_back(make_instr(OP_SLTI, 5'd13, 5'd2, 5'd0, 32'h0000_8000));
      pending_instrs.push_back(make_instr(OP_ANDI, 5'd14, 5'd2, 5'd0, 32'hFFFF_FFFF));
      pending_instrs.push_back(make_instr(OP_XORI, 5'd16, 5'd2, 5'd0, 32'h0000_FFFF));
      pending_instrs.push_back(make_instr(OP_ADD, 5'd0, 5'd2, 5'd2, 32'd0));
      pending_instrs.push_back(make_instr(OP_SW, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFC));
      pending_instrs.push_back(make_instr(OP_LW, 5'd17, 5'd0, 5'd0, 32'hFFFF_FFFC));
      pending_instrs.push_back(make_instr(OP_LW, 5'd18, 5'd0, 5'd1, 32'h8000_0000));
      pending_instrs.push_back(make_instr(OP_BEQ, 5'd0, 5'd0, 5'd0, 32'd0));
      pending_instrs.push_back(make_instr(OP_J, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFF));
      pending_instrs.push_back(make_instr(OP_BNE, 5'd1, 5'd2, 5'd0, 32'd100));
      pending_instrs.push_back(make_instr(OP_JAL, 5'd0, 5'd0, 5'd0, 32'd5));
      pending_instrs.push_back(make_instr(OP_JR, 5'd31, 5'd0, 5'd0, 32'd0));
      pending_instrs.push_back(make_instr(OP_JALR, 5'd7, 5'd7, 5'd0, 32'd0));
      pending_instrs.push_back(make_instr(OP_JALR, 5'd2, 5'd0, 5'd0, 32'd0));
      pending_instrs.push_back(make_instr(OP_SPARE_HI, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF));
      directed_count = pending_instrs.size();
      drain_points.push_back(directed_count);
      drain_points.push_back(directed_count + NUM_INSTRS / 2);

      // Random part: mostly free instruction mixes, with store/load pairs to the same word.
      while (pending_instrs.size() < directed_count + NUM_INSTRS) begin
         if ($urandom_range(0, 99) < 15) begin
            base = ($urandom_range(0, 1) == 0) ? REG_ZERO : pick_reg();
            offset = $urandom_range(0, 63) << 2;
            src = pick_reg();
            dst = pick_reg();
            pending_instrs.push_back(make_instr(OP_SW, src, pick_reg(), base, offset));
            if ($urandom_range(0, 1) == 0) begin
               pending_instrs.push_back(random_instr());
            end
            pending_instrs.push_back(make_instr(OP_LW, dst, pick_reg(), base, offset));
         end else begin
            pending_instrs.push_back(random_instr());
         end
      end

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      while (pending_instrs.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d instructions (%0d directed) and checked %0d results.",
               sent_count, directed_count, checked_count);
      $display("Stores %0d, loads %0d, taken branches and jumps %0d, mismatches %0d.",
               store_count, load_count, taken_count, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* mips_subset_execute_unit.f */
hdl/mse_pkg.sv
hdl/mse_front.sv
hdl/mse_queue.sv
hdl/mse_back.sv
hdl/mips_subset_execute_unit.sv
tb/sv/tb_mips_subset_execute_unit.sv
